// ===== design/uifb_pkg.sv =====
// ----------------------------------------------------------------------------
// uifb_pkg
// Shared types and constants for the UART interrupt FIFO buffer core:
// opcodes, controller states, item and result layouts, control structs.
// ----------------------------------------------------------------------------
package uifb_pkg;

  localparam int unsigned OpW   = 3;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CntW  = 32;

  // Transaction opcodes
  typedef enum logic [OpW-1:0] {
    OP_WRITE   = 3'd0,
    OP_READ    = 3'd1,
    OP_SERVICE = 3'd2,
    OP_OPEN    = 3'd3,
    OP_CLOSE   = 3'd4
  } op_e;

  // Controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // Input item payload, first field in the highest bits
  typedef struct packed {
    logic [ByteW-1:0] line_rx_byte;
    logic             line_overrun;
    logic             line_tx_empty;
    logic             line_data_ready;
    logic [ByteW-1:0] data_byte;
  } item_t;

  localparam int unsigned ItemW  = $bits(item_t);
  localparam int unsigned SDataW = ((ItemW + 7) / 8) * 8;

  // Result payload, first field in the highest bits
  typedef struct packed {
    logic [CntW-1:0]  overrun_total;
    logic             tx_irq_enable;
    logic             rx_irq_enable;
    logic             rx_dropped;
    logic [ByteW-1:0] send_byte;
    logic             send_valid;
    logic [ByteW-1:0] read_byte;
  } result_t;

  localparam int unsigned ResW   = $bits(result_t);
  localparam int unsigned MDataW = ((ResW + 7) / 8) * 8;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch item, launch queue reads
    logic commit;   // update state, load output register
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_stall;  // output register full and not being drained
  } dp_status_t;

endpackage

// ===== design/uart_irq_fifo_buffer_core.sv =====
// ----------------------------------------------------------------------------
// uart_irq_fifo_buffer_core
// Receive and transmit byte ring buffers between a host and a UART line,
// with interrupt enable tracking and a saturating overrun counter.
// ----------------------------------------------------------------------------
// Sequence: an accepted transaction goes to the exec state and its result is
//   registered on commit, which waits while the output register is stalled.
// Transactions: one in flight at a time; the queue stores are read at
//   the head on accept and the registered read data is used in the next cycle.
// A finished result may wait in the output register while the next
//   transaction is accepted and executed up to commit.
// Reset: asynchronous, active low; pointers, enables and counter clear,
//   store contents are left as they are.
module uart_irq_fifo_buffer_core #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] data_byte, [8] line_data_ready, [9] line_tx_empty,
  // [10] line_overrun, [18:11] line_rx_byte, upper bits zero
  input  logic [uifb_pkg::SDataW-1:0]   s_axis_tdata,
  // [2:0] opcode
  input  logic [uifb_pkg::OpW-1:0]      s_axis_tuser,
  // Output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] read_byte, [8] send_valid, [16:9] send_byte, [17] rx_dropped,
  // [18] rx_irq_enable, [19] tx_irq_enable, [51:20] overrun_total,
  // upper bits zero
  output logic [uifb_pkg::MDataW-1:0]   m_axis_tdata,
  // [0] status
  output logic                          m_axis_tuser
);
  import uifb_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;
  result_t    result;

  // Sequencer
  uifb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Queues and result register
  uifb_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .opcode_i   (s_axis_tuser),
    .item_i     (item_t'(s_axis_tdata[ItemW-1:0])),
    .m_ready_i  (m_axis_tready),
    .m_valid_o  (m_axis_tvalid),
    .m_status_o (m_axis_tuser),
    .m_result_o (result)
  );

  assign m_axis_tdata = {{(MDataW - ResW){1'b0}}, result};

  // One transaction in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("transaction accepted while previous one executing");

  // Send byte is zero unless a byte goes to the line
  a_send_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !result.send_valid) |-> (result.send_byte == '0))
    else $error("send_byte nonzero without send_valid");

  // A would-block result carries no read byte and sends nothing
  a_block_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (result.read_byte == '0 && !result.send_valid))
    else $error("would-block result carries data");

  // A dropped receive byte leaves the receive interrupt disabled
  a_drop_clears_ie: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && result.rx_dropped) |-> !result.rx_irq_enable)
    else $error("rx_dropped with rx_irq_enable set");

endmodule

// ===== design/uifb_ram.sv =====
// ----------------------------------------------------------------------------
// uifb_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module uifb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/uifb_ctrl.sv =====
// ----------------------------------------------------------------------------
// uifb_ctrl
// Sequencer: takes one transaction, then commits it once the output
// register can take the result.
// ----------------------------------------------------------------------------
module uifb_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_valid_i,
  output logic                   s_ready_o,
  input  uifb_pkg::dp_status_t   sts_i,
  output uifb_pkg::ctrl_cmd_t    cmd_o
);
  import uifb_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    s_ready_o     = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o     = 1'b1;
        cmd_o.capture = s_valid_i;
        if (s_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!sts_i.out_stall) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/uifb_datapath.sv =====
// ----------------------------------------------------------------------------
// uifb_datapath
// Queue pointers, interrupt enables, overrun counter, the two byte stores
// and the output register.
// ----------------------------------------------------------------------------
module uifb_datapath #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  uifb_pkg::ctrl_cmd_t           cmd_i,
  output uifb_pkg::dp_status_t          sts_o,
  input  logic [uifb_pkg::OpW-1:0]      opcode_i,
  input  uifb_pkg::item_t               item_i,
  input  logic                          m_ready_i,
  output logic                          m_valid_o,
  output logic                          m_status_o,
  output uifb_pkg::result_t             m_result_o
);
  import uifb_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned PW = $clog2(2 * QUEUE_DEPTH);
  localparam logic [PW-1:0] PtrLast = PW'(2 * QUEUE_DEPTH - 1);
  localparam logic [PW-1:0] Depth   = PW'(QUEUE_DEPTH);

  // Storage slot of a pointer that runs modulo twice the depth
  function automatic logic [AW-1:0] slot(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p >= Depth) ? (p - Depth) : p;
    return r[AW-1:0];
  endfunction

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PtrLast) ? '0 : (p + PW'(1));
  endfunction

  logic [PW-1:0]    rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [PW-1:0]    tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic             rx_ie_q, rx_ie_d, tx_ie_q, tx_ie_d;
  logic [CntW-1:0]  ovr_q, ovr_d;
  logic [OpW-1:0]   opcode_q;
  item_t            item_q;
  logic             out_valid_q;
  logic             status_q, status_d;
  result_t          res_q, res_d;
  logic             rx_we, tx_we;
  logic [ByteW-1:0] rx_rdata, tx_rdata;
  logic             rx_empty, rx_full, tx_empty, tx_full;

  // Item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      opcode_q <= opcode_i;
      item_q   <= item_i;
    end
  end

  // Byte stores, read at the head when the item is captured
  uifb_ram #(.WIDTH(ByteW), .DEPTH(QUEUE_DEPTH)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (slot(rx_tail_q)),
    .wdata_i (item_q.line_rx_byte),
    .re_i    (cmd_i.capture),
    .raddr_i (slot(rx_head_q)),
    .rdata_o (rx_rdata)
  );

  uifb_ram #(.WIDTH(ByteW), .DEPTH(QUEUE_DEPTH)) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (slot(tx_tail_q)),
    .wdata_i (item_q.data_byte),
    .re_i    (cmd_i.capture),
    .raddr_i (slot(tx_head_q)),
    .rdata_o (tx_rdata)
  );

  // Queue flags: full when pointers differ but share a slot
  assign rx_empty = (rx_head_q == rx_tail_q);
  assign tx_empty = (tx_head_q == tx_tail_q);
  assign rx_full  = !rx_empty && (slot(rx_head_q) == slot(rx_tail_q));
  assign tx_full  = !tx_empty && (slot(tx_head_q) == slot(tx_tail_q));

  // Opcode execution
  always_comb begin
    rx_head_d = rx_head_q;
    rx_tail_d = rx_tail_q;
    tx_head_d = tx_head_q;
    tx_tail_d = tx_tail_q;
    rx_ie_d   = rx_ie_q;
    tx_ie_d   = tx_ie_q;
    ovr_d     = ovr_q;
    status_d  = 1'b0;
    res_d     = '0;
    rx_we     = 1'b0;
    tx_we     = 1'b0;
    case (opcode_q)
      OP_WRITE: begin
        tx_ie_d = 1'b1;
        if (tx_full) begin
          status_d = 1'b1;
        end else begin
          tx_we     = cmd_i.commit;
          tx_tail_d = ptr_inc(tx_tail_q);
        end
      end
      OP_READ: begin
        rx_ie_d = 1'b1;
        if (rx_empty) begin
          status_d = 1'b1;
        end else begin
          res_d.read_byte = rx_rdata;
          rx_head_d       = ptr_inc(rx_head_q);
        end
      end
      OP_SERVICE: begin
        if (item_q.line_data_ready) begin
          if (!rx_full) begin
            rx_we     = cmd_i.commit;
            rx_tail_d = ptr_inc(rx_tail_q);
          end else begin
            res_d.rx_dropped = 1'b1;
            rx_ie_d          = 1'b0;
          end
        end
        if (item_q.line_tx_empty) begin
          if (!tx_empty) begin
            res_d.send_valid = 1'b1;
            res_d.send_byte  = tx_rdata;
            tx_head_d        = ptr_inc(tx_head_q);
          end else begin
            tx_ie_d = 1'b0;
          end
        end
        // saturating overrun count
        if (item_q.line_overrun && (ovr_q != '1)) begin
          ovr_d = ovr_q + CntW'(1);
        end
      end
      OP_OPEN: begin
        rx_head_d = '0;
        rx_tail_d = '0;
        tx_head_d = '0;
        tx_tail_d = '0;
        rx_ie_d   = 1'b1;
      end
      OP_CLOSE: begin
        rx_ie_d = 1'b0;
        tx_ie_d = 1'b0;
      end
      default: begin
      end
    endcase
    res_d.rx_irq_enable = rx_ie_d;
    res_d.tx_irq_enable = tx_ie_d;
    res_d.overrun_total = ovr_d;
  end

  // Architectural state, updated on commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q <= '0;
      rx_tail_q <= '0;
      tx_head_q <= '0;
      tx_tail_q <= '0;
      rx_ie_q   <= 1'b0;
      tx_ie_q   <= 1'b0;
      ovr_q     <= '0;
    end else if (cmd_i.commit) begin
      rx_head_q <= rx_head_d;
      rx_tail_q <= rx_tail_d;
      tx_head_q <= tx_head_d;
      tx_tail_q <= tx_tail_d;
      rx_ie_q   <= rx_ie_d;
      tx_ie_q   <= tx_ie_d;
      ovr_q     <= ovr_d;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q <= status_d;
      res_q    <= res_d;
    end
  end

  assign sts_o.out_stall = out_valid_q && !m_ready_i;
  assign m_valid_o       = out_valid_q;
  assign m_status_o      = status_q;
  assign m_result_o      = res_q;

endmodule
